FILE: rtl/rspe_pkg.sv
// ----------------------------------------------------------------------------
// rspe_pkg: shared types, codes and GF(256) helpers
// Field codes, parity counts per mode, remainder control bundle and
// constant functions that build the generator polynomials.
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

    // Parity byte counts per mode (mode three behaves as mode two)
    localparam int PARITY_CNT_MODE0 = 16;
    localparam int PARITY_CNT_MODE1 = 32;
    localparam int PARITY_CNT_MODE2 = 64;

    // Largest generator kept in a table
    localparam int GEN_MAX = 64;

    // Code word span in bytes
    localparam logic [7:0] CODE_SPAN = 8'd255;

    // Parity mode register codes
    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_32 = 2'd1;
    localparam logic [1:0] MODE_64 = 2'd2;
    localparam logic [1:0] MODE_ALT = 2'd3;

    // Input command codes
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // Generator coefficients, index is the power of x
    typedef logic [GEN_MAX:0][7:0] gen_t;

    // Control bundle for the remainder register operation
    typedef struct packed {
        logic       absorb;
        logic       shift_out;
        logic       clear_all;
        logic [1:0] gen_sel;
    } rem_ctrl_t;

    // Multiply two field elements, reduce by the field polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [8:0] poly);
        logic [8:0] x;
        logic [7:0] acc;
        x   = {1'b0, a};
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ poly;
            end
            x[8] = 1'b0;
        end
        return acc;
    endfunction

    // Build product of (x - a^i) for i = 0 .. n-1
    function automatic gen_t gen_poly(input int n, input logic [8:0] poly);
        gen_t       g;
        logic [7:0] root;
        g    = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j >= 1; j--) begin
                g[j] = g[j-1] ^ gf_mul(g[j], root, poly);
            end
            g[0] = gf_mul(g[0], root, poly);
            root = gf_mul(root, 8'h02, poly);
        end
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/reed_solomon_parity_encoder.sv
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder: systematic RS(255) parity encoder over GF(256)
// Echoes message bytes while dividing them into the remainder register;
// a finish transaction streams out 16, 32 or 64 parity bytes, or a single status byte for an empty or too-long message.
//
//   channel   | direction | tdata                 | tuser                 | tlast
//   s_        | in        | [7:0] data_byte       | [0] command           | -
//   m_        | out       | [7:0] code_byte       | [0] is_parity,        | last
//             |           |                       | [2:1] status          |
//   cfg_      | in        | [1:0] parity_mode     | -                     | -
//
// A message byte's echo appears the next cycle; a new byte is taken every
// cycle while the output is drained and no parity drain is running.
// A finish gives n parity bytes (n = 16, 32 or 64) at one per cycle while
// the output is drained; the input is held off while the parity shifts
// out of the remainder register, one entry per parity byte.
// Synchronous reset clears the remainder, the byte count and the mode.
// Output stalls back up into the input through tready.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder import rspe_pkg::*; #(
    parameter int MAX_PARITY = 64,
    parameter int FIELD_POLY = 285
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_tuser,   // [0] command
    // result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] code_byte
    output logic [2:0]      m_tuser,   // [0] is_parity, [2:1] status
    output logic            m_tlast,
    // configuration write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data   // [1:0] parity_mode
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int N0 = (PARITY_CNT_MODE0 < MAX_PARITY) ? PARITY_CNT_MODE0 : MAX_PARITY;
    localparam int N1 = (PARITY_CNT_MODE1 < MAX_PARITY) ? PARITY_CNT_MODE1 : MAX_PARITY;
    localparam int N2 = (PARITY_CNT_MODE2 < MAX_PARITY) ? PARITY_CNT_MODE2 : MAX_PARITY;

    logic [1:0]    mode_reg;
    logic [7:0]    count_reg, count_next;
    logic [CW-1:0] drain_reg, drain_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic [2:0]    m_user_reg, m_user_next;
    logic          m_last_reg, m_last_next;

    logic [1:0]    gen_sel;
    logic [CW-1:0] n_cnt;
    logic [7:0]    limit;
    logic          s_acc;
    logic          out_free;
    logic          draining;
    logic          is_finish;
    rem_ctrl_t     rem_ctrl;
    logic [7:0]    top_byte;

    // Mode three uses the 64 byte generator
    assign gen_sel = (mode_reg == MODE_ALT) ? MODE_64 : mode_reg;

    always_comb begin
        case (gen_sel)
            MODE_16: n_cnt = CW'(N0);
            MODE_32: n_cnt = CW'(N1);
            default: n_cnt = CW'(N2);
        endcase
    end

    assign limit     = CODE_SPAN - 8'(n_cnt);
    assign out_free  = !m_valid_reg || m_tready;
    assign draining  = (drain_reg != '0);
    assign s_tready  = out_free && !draining;
    assign s_acc     = s_tvalid && s_tready;
    assign is_finish = (s_tuser[0] == CMD_FINISH);
    assign cfg_ready = 1'b1;

    // Next state and next result
    always_comb begin
        count_next   = count_reg;
        drain_next   = drain_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        rem_ctrl     = '0;
        rem_ctrl.gen_sel = gen_sel;

        if (s_acc) begin
            m_valid_next = 1'b1;
            if (!is_finish) begin
                // echo the byte; absorb it unless the message is full
                m_data_next = s_tdata;
                m_last_next = 1'b0;
                if (count_reg >= limit) begin
                    m_user_next = {STATUS_TOO_LONG, 1'b0};
                end else begin
                    m_user_next     = {STATUS_OK, 1'b0};
                    rem_ctrl.absorb = 1'b1;
                    count_next      = count_reg + 8'd1;
                end
            end else begin
                count_next = 8'd0;
                if (count_reg == 8'd0) begin
                    m_data_next        = 8'h00;
                    m_user_next        = {STATUS_EMPTY, 1'b0};
                    m_last_next        = 1'b1;
                    rem_ctrl.clear_all = 1'b1;
                end else if (count_reg > limit) begin
                    m_data_next        = 8'h00;
                    m_user_next        = {STATUS_TOO_LONG, 1'b0};
                    m_last_next        = 1'b1;
                    rem_ctrl.clear_all = 1'b1;
                end else begin
                    // first parity byte now, the rest drain
                    m_data_next        = top_byte;
                    m_user_next        = {STATUS_OK, 1'b1};
                    m_last_next        = 1'b0;
                    rem_ctrl.shift_out = 1'b1;
                    drain_next         = n_cnt - CW'(1);
                end
            end
        end else if (draining && out_free) begin
            // advance the parity drain
            m_valid_next       = 1'b1;
            m_data_next        = top_byte;
            m_user_next        = {STATUS_OK, 1'b1};
            m_last_next        = (drain_reg == CW'(1));
            rem_ctrl.shift_out = 1'b1;
            drain_next         = drain_reg - CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_16;
            count_reg   <= 8'd0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    rspe_remainder #(
        .MAX_PARITY (MAX_PARITY),
        .FIELD_POLY (FIELD_POLY)
    ) u_remainder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rem_ctrl),
        .data_byte (s_tdata),
        .top_byte  (top_byte)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Hold off input while parity drains
    a_drain_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        draining |-> !s_tready)
        else $error("input accepted during parity drain");

    // Any finish restarts the message count
    a_finish_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_finish) |=> (count_reg == 8'd0))
        else $error("message count not cleared by finish");

    // The marked parity byte ends the drain
    a_last_parity_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg && m_user_reg[0]) |-> !draining)
        else $error("last parity byte shown while drain still active");

endmodule

`default_nettype wire

FILE: rtl/rspe_remainder.sv
// ----------------------------------------------------------------------------
// rspe_remainder: parity division register
// Holds the remainder of m(x) * x^n mod g(x). One message byte is absorbed
// per cycle while absorb is set, through parallel constant-table GF
// multipliers; parity bytes leave from the top entry by shifting up.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_remainder import rspe_pkg::*; #(
    parameter int MAX_PARITY = 64,
    parameter int FIELD_POLY = 285
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire rem_ctrl_t  ctrl,
    input  wire logic [7:0] data_byte,
    output logic [7:0]      top_byte
);

    // Parity counts clamped to the register depth
    localparam int N0 = (PARITY_CNT_MODE0 < MAX_PARITY) ? PARITY_CNT_MODE0 : MAX_PARITY;
    localparam int N1 = (PARITY_CNT_MODE1 < MAX_PARITY) ? PARITY_CNT_MODE1 : MAX_PARITY;
    localparam int N2 = (PARITY_CNT_MODE2 < MAX_PARITY) ? PARITY_CNT_MODE2 : MAX_PARITY;

    localparam gen_t GEN0 = gen_poly(N0, 9'(FIELD_POLY));
    localparam gen_t GEN1 = gen_poly(N1, 9'(FIELD_POLY));
    localparam gen_t GEN2 = gen_poly(N2, 9'(FIELD_POLY));

    logic [7:0] rem_reg  [MAX_PARITY];
    logic [7:0] rem_next [MAX_PARITY];
    logic [7:0] feedback;

    // Select the highest active entry for the current mode
    always_comb begin
        case (ctrl.gen_sel)
            MODE_16: top_byte = rem_reg[N0-1];
            MODE_32: top_byte = rem_reg[N1-1];
            default: top_byte = rem_reg[N2-1];
        endcase
    end

    assign feedback = data_byte ^ top_byte;

    // Per-entry update
    for (genvar g = 0; g < MAX_PARITY; g++) begin : g_entry
        logic [7:0] prev;
        logic [7:0] coef;
        logic       in_use;

        if (g == 0) begin : g_first
            assign prev = 8'h00;
        end else begin : g_rest
            assign prev = rem_reg[g-1];
        end

        always_comb begin
            case (ctrl.gen_sel)
                MODE_16: begin
                    coef   = GEN0[g];
                    in_use = (g < N0);
                end
                MODE_32: begin
                    coef   = GEN1[g];
                    in_use = (g < N1);
                end
                default: begin
                    coef   = GEN2[g];
                    in_use = (g < N2);
                end
            endcase
        end

        always_comb begin
            rem_next[g] = rem_reg[g];
            if (ctrl.clear_all) begin
                rem_next[g] = 8'h00;
            end else if (ctrl.absorb) begin
                if (in_use) begin
                    rem_next[g] = prev ^ gf_mul(feedback, coef, 9'(FIELD_POLY));
                end
            end else if (ctrl.shift_out) begin
                rem_next[g] = in_use ? prev : 8'h00;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rem_reg[g] <= 8'h00;
            end else begin
                rem_reg[g] <= rem_next[g];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for reed_solomon_parity_encoder
// Streams message bytes and finish transactions through the encoder in all
// four parity modes. A log/antilog GF(256) model predicts every echoed byte,
// parity byte and status flag. Both stream sides idle at random, and the
// result side also holds off for a long stretch to back the input up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import rspe_pkg::*; ();

    localparam int FIELD_POLY  = 'h11d;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 8;

    typedef struct {
        logic       command;
        logic [7:0] data_byte;
    } enc_item_t;

    typedef struct {
        logic [7:0] code_byte;
        logic       is_parity;
        logic       last;
        logic [1:0] status;
    } code_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0] s_tuser = 1'b0;    // [0] command
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] code_byte
    logic [2:0] m_tuser;           // [0] is_parity, [2:1] status
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'd0;   // [1:0] parity_mode

    // GF(256) tables and generator coefficients per mode
    logic [7:0] alog [0:254];
    int         ilog [0:255];
    logic [7:0] gen_coef [0:2][0:64];

    // Encoder shadow state
    logic [7:0] rem_bytes [0:63];
    int         msg_count;
    logic [1:0] mode_shadow;

    enc_item_t    pending_items[$];
    code_result_t expected_codes[$];
    enc_item_t    next_item;

    int idle_pct = 30;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int items_queued = 0;
    int items_sent = 0;
    int results_checked = 0;
    int parity_blocks = 0;
    int empty_finishes = 0;
    int too_long_flags = 0;
    int fail_count = 0;

    reed_solomon_parity_encoder #(
        .MAX_PARITY (64),
        .FIELD_POLY (FIELD_POLY)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Multiply through the log tables
    function automatic logic [7:0] ff_mul(input logic [7:0] a, input logic [7:0] b);
        if (a == 8'h00 || b == 8'h00) begin
            return 8'h00;
        end
        return alog[(ilog[a] + ilog[b]) % 255];
    endfunction

    function automatic int parity_count(input logic [1:0] mode);
        case (mode)
            MODE_16: return PARITY_CNT_MODE0;
            MODE_32: return PARITY_CNT_MODE1;
            default: return PARITY_CNT_MODE2;
        endcase
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic clear_message();
        for (int i = 0; i < 64; i++) begin
            rem_bytes[i] = 8'h00;
        end
        msg_count = 0;
    endtask

    // Work out the results of one accepted transaction
    task automatic predict_codeword(input logic cmd, input logic [7:0] data);
        int           n;
        int           gi;
        int           span_left;
        logic [7:0]   fb;
        code_result_t r;
        n         = parity_count(mode_shadow);
        gi        = (mode_shadow == MODE_ALT) ? 2 : int'(mode_shadow);
        span_left = int'(CODE_SPAN) - n;
        if (cmd == CMD_BYTE) begin
            r.code_byte = data;
            r.is_parity = 1'b0;
            r.last      = 1'b0;
            if (msg_count >= span_left) begin
                r.status = STATUS_TOO_LONG;
            end else begin
                fb = data ^ rem_bytes[n-1];
                for (int i = n - 1; i >= 1; i--) begin
                    rem_bytes[i] = rem_bytes[i-1] ^ ff_mul(fb, gen_coef[gi][i]);
                end
                rem_bytes[0] = ff_mul(fb, gen_coef[gi][0]);
                msg_count++;
                r.status = STATUS_OK;
            end
            expected_codes.push_back(r);
        end else if (msg_count == 0 || msg_count > span_left) begin
            r.code_byte = 8'h00;
            r.is_parity = 1'b0;
            r.last      = 1'b1;
            r.status    = (msg_count == 0) ? STATUS_EMPTY : STATUS_TOO_LONG;
            expected_codes.push_back(r);
            clear_message();
        end else begin
            for (int k = 0; k < n; k++) begin
                r.code_byte = rem_bytes[n-1-k];
                r.is_parity = 1'b1;
                r.last      = (k == n - 1);
                r.status    = STATUS_OK;
                expected_codes.push_back(r);
            end
            clear_message();
        end
    endtask

    task automatic queue_item(input logic cmd, input logic [7:0] data);
        enc_item_t it;
        it.command   = cmd;
        it.data_byte = data;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Random message body followed by a finish carrying random filler
    task automatic queue_message(input int len);
        repeat (len) begin
            queue_item(CMD_BYTE, 8'($urandom));
        end
        queue_item(CMD_FINISH, 8'($urandom));
    endtask

    // Let everything in flight come out
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_codes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_parity_mode(input logic [1:0] mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid   <= 1'b0;
        mode_shadow = mode;
    endtask

    // Input driver: offer queued transactions, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_codeword(s_tuser[0], s_tdata);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.command;
                    s_tdata  <= next_item.data_byte;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: long hold-offs on request, random stalls otherwise
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served < hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Result monitor: compare each transaction with the oldest prediction
    always @(posedge aclk) begin
        code_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected result: code_byte %0h tuser %0h tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                exp_r = expected_codes.pop_front();
                results_checked++;
                if (m_tdata !== exp_r.code_byte) begin
                    $error("code_byte mismatch: expected %0h, actual %0h",
                           exp_r.code_byte, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_r.is_parity) begin
                    $error("is_parity mismatch: expected %0b, actual %0b",
                           exp_r.is_parity, m_tuser[0]);
                    fail_count++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last mismatch: expected %0b, actual %0b", exp_r.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser[2:1] !== exp_r.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_r.status, m_tuser[2:1]);
                    fail_count++;
                end
                if (exp_r.last && exp_r.is_parity) begin
                    parity_blocks++;
                end
                if (exp_r.status == STATUS_EMPTY) begin
                    empty_finishes++;
                end
                if (exp_r.status == STATUS_TOO_LONG) begin
                    too_long_flags++;
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        int v;
        int phase;
        int kind;
        int n;
        int base;

        // Build field tables and generators
        v = 1;
        for (int i = 0; i < 255; i++) begin
            alog[i] = 8'(v);
            ilog[v] = i;
            v = v << 1;
            if (v & 'h100) begin
                v = v ^ FIELD_POLY;
            end
        end
        ilog[0] = 0;
        for (int m = 0; m < 3; m++) begin
            n = parity_count(2'(m));
            for (int j = 0; j <= 64; j++) begin
                gen_coef[m][j] = 8'h00;
            end
            gen_coef[m][0] = 8'h01;
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j >= 1; j--) begin
                    gen_coef[m][j] = gen_coef[m][j-1] ^ ff_mul(gen_coef[m][j], alog[i]);
                end
                gen_coef[m][0] = ff_mul(gen_coef[m][0], alog[i]);
            end
        end
        clear_message();
        mode_shadow = MODE_16;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty finishes, extreme bytes, all-zero message
        write_parity_mode(MODE_16);
        queue_item(CMD_FINISH, 8'h00);
        queue_item(CMD_BYTE, 8'h00);
        queue_item(CMD_BYTE, 8'hff);
        queue_item(CMD_BYTE, 8'h80);
        queue_item(CMD_BYTE, 8'h01);
        queue_item(CMD_FINISH, 8'h00);
        queue_item(CMD_BYTE, 8'h00);
        queue_item(CMD_FINISH, 8'hff);
        queue_item(CMD_FINISH, 8'hff);
        wait_drained();

        write_parity_mode(MODE_32);
        queue_item(CMD_BYTE, 8'hff);
        queue_item(CMD_BYTE, 8'h55);
        queue_item(CMD_BYTE, 8'haa);
        queue_item(CMD_FINISH, 8'h00);
        wait_drained();

        // Mode three acts as 64 parity bytes
        write_parity_mode(MODE_ALT);
        queue_item(CMD_BYTE, 8'h7f);
        queue_item(CMD_BYTE, 8'hfe);
        queue_item(CMD_FINISH, 8'h00);
        wait_drained();

        // Long message in mode 16 with the result side held off so the
        // input backs up; one byte more than a 64-parity message can take
        write_parity_mode(MODE_16);
        idle_pct = 0;
        hold_requests++;
        repeat (int'(CODE_SPAN) - PARITY_CNT_MODE2 + 1) begin
            queue_item(CMD_BYTE, 8'($urandom));
        end
        wait_drained();

        // Switch to 64: further bytes and the first finish are flagged too long
        idle_pct = 30;
        write_parity_mode(MODE_64);
        queue_item(CMD_BYTE, 8'hff);
        queue_item(CMD_BYTE, 8'h00);
        queue_item(CMD_FINISH, 8'h00);
        queue_item(CMD_FINISH, 8'h00);
        wait_drained();

        // Random phases: mostly whole messages, some stray bytes and finishes
        base  = items_queued;
        phase = 0;
        while (items_queued - base < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 60;
            endcase
            write_parity_mode(2'($urandom_range(3)));
            repeat ($urandom_range(3, 6)) begin
                kind = $urandom_range(9);
                if (kind == 0) begin
                    queue_item(CMD_FINISH, 8'($urandom));
                end else if (kind == 1) begin
                    queue_item(CMD_BYTE, 8'($urandom));
                end else begin
                    queue_message($urandom_range(1, (kind == 9) ? 12 : 5));
                end
            end
            if (phase == 2) begin
                hold_requests++;
            end
            phase++;
            wait_drained();
        end

        // Close out any message left open, then settle
        queue_item(CMD_FINISH, 8'h00);
        while (pending_items.size() != 0 || s_tvalid || expected_codes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (expected_codes.size() != 0) begin
            $error("%0d expected results never arrived", expected_codes.size());
            fail_count++;
        end

        $display("Run: %0d input transactions, %0d results checked, all four parity modes",
                 items_sent, results_checked);
        $display("Run: %0d parity blocks, %0d empty finishes, %0d too-long flags",
                 parity_blocks, empty_finishes, too_long_flags);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Timeout: run did not complete");
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
